[rtl/seglk_pkg.sv]
// ----------------------------------------------------------------------------
// seglk_pkg
// Shared types and codes for the segment label lookup block.
// ----------------------------------------------------------------------------
package seglk_pkg;

  // Command codes carried by an input beat.
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // Status codes carried by a result beat.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // One input beat.
  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] breakpoint;
    logic [7:0]  left_label;
    logic [7:0]  right_label;
    logic [31:0] query_position;
  } in_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] left_result;
    logic [7:0] right_result;
    logic [1:0] status;
  } out_t;

  // One stored segment.
  typedef struct packed {
    logic [31:0] breakpoint;
    logic [7:0]  left_label;
    logic [7:0]  right_label;
  } entry_t;

endpackage

[rtl/segment_label_lookup.sv]
// ----------------------------------------------------------------------------
// segment_label_lookup
// Per-sample lookup of left and right labels against sorted segment ends.
// ----------------------------------------------------------------------------
//
//   channel   handshake                    payload               direction
//   item      item_valid / item_ready      item   (in_t)          in
//   result    result_valid / result_ready  result (out_t)         out
//
// Clear and load beats complete in the idle state. A query scans the table,
// advancing the pointer per compare; the single read port of the segment
// table is read once per compare.
// Reset clears the count, the pointer and the overflow flag; the table itself
// needs no clearing pass, since only entries below the count are ever used.
// A finished result waits in the output register; clears and loads are still
// taken meanwhile, while a query holds in the scan until that register frees.
// ----------------------------------------------------------------------------
module segment_label_lookup #(
  parameter int MAX_SEGMENTS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  seglk_pkg::in_t    item,
  output logic              result_valid,
  input  logic              result_ready,
  output seglk_pkg::out_t   result
);
  import seglk_pkg::*;

  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [CW-1:0] pointer;
  logic          overflow;
  logic [31:0]   pos;

  logic          accept;
  logic          room;
  logic          advance;
  logic          slot_free;
  logic          finish;
  logic [CW-1:0] pointer_next;
  logic [CW-1:0] last;
  logic [CW-1:0] rd_sel;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  entry_t        wr_data;
  entry_t        rd_data;
  out_t          found;

  // Handshake and table bookkeeping.
  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign room       = (count < CW'(MAX_SEGMENTS));
  assign slot_free  = !result_valid || result_ready;

  // The scan compares the entry under the pointer with the query position.
  assign advance      = (state == S_SCAN) && (pointer < count) &&
                        (pos >= rd_data.breakpoint);
  assign finish       = (state == S_SCAN) && !advance && slot_free;
  assign pointer_next = advance ? pointer + 1'b1 : pointer;

  // Read the entry for the next compare, clamped to the last segment so that
  // a pointer past the end still yields the last labels.
  assign last    = count - 1'b1;
  assign rd_sel  = (pointer_next < count) ? pointer_next : last;
  assign rd_addr = rd_sel[AW-1:0];

  // Loads append at the current count.
  assign wr_en   = accept && (item.command == CMD_LOAD) && room;
  assign wr_data = '{breakpoint:  item.breakpoint,
                     left_label:  item.left_label,
                     right_label: item.right_label};

  // Result beat built from the entry the scan stopped on.
  always_comb begin
    if (count == '0) begin
      found = '{left_result: 8'd0, right_result: 8'd0, status: STATUS_EMPTY};
    end else begin
      found = '{left_result:  rd_data.left_label,
                right_result: rd_data.right_label,
                status:       overflow ? STATUS_OVERFLOW : STATUS_OK};
    end
  end

  seglk_mem #(
    .DEPTH (MAX_SEGMENTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Control state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      pointer      <= '0;
      overflow     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // The result register fills on a finished scan and empties once taken.
      if (finish) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (item.command)
              CMD_CLEAR: begin
                count   <= '0;
                pointer <= '0;
              end
              CMD_LOAD: begin
                if (room) begin
                  count <= count + 1'b1;
                end else begin
                  overflow <= 1'b1;
                end
              end
              CMD_QUERY: begin
                pos   <= item.query_position;
                state <= S_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          pointer <= pointer_next;
          if (finish) begin
            result <= found;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/seglk_mem.sv]
// ----------------------------------------------------------------------------
// seglk_mem
// Segment table: one write port and one registered read port.
// ----------------------------------------------------------------------------
module seglk_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  seglk_pkg::entry_t   wr_data,
  input  logic [AW-1:0]       rd_addr,
  output seglk_pkg::entry_t   rd_data
);
  import seglk_pkg::*;

  entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/seglk_checker.sv]
// ----------------------------------------------------------------------------
// seglk_checker
// Port-level checks on the segment label lookup block, bound to the top.
// ----------------------------------------------------------------------------
module seglk_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input seglk_pkg::in_t    item,
  input logic              result_valid,
  input logic              result_ready,
  input seglk_pkg::out_t   result
);
  import seglk_pkg::*;

  // A stalled result beat holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // No result is pending right after reset.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A query keeps the input side busy in the cycle after it is taken.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (item.command == CMD_QUERY) |=> !item_ready)
    else $error("input taken during a query scan");

  // Clear and load beats never produce a result.
  assert property (@(posedge clk) disable iff (rst)
    !result_valid && item_valid && item_ready && (item.command != CMD_QUERY)
    |=> !result_valid)
    else $error("result produced by a non-query beat");

endmodule

bind segment_label_lookup seglk_checker u_seglk_checker (.*);
